>>> rtl/lph_pkg.sv
// shared types and constants for the linear probe hash table
`timescale 1ns / 1ps

package lph_pkg;

  // fixed widths of the transaction fields
  localparam int DATA_W = 64;
  localparam int IN_KEY_W = 64;
  localparam int FILL_W = 10;

  // operation codes carried on cmd
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  // per-slot state codes
  localparam int SLOT_W = 2;
  localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_LIVE  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_TOMB  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic clear_wr;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic slot_hit;
    logic slot_empty;
    logic probe_last;
    logic clear_last;
  } dp_status_t;

endpackage

>>> rtl/lph_ctrl.sv
// controller state machine for the linear probe hash table
`timescale 1ns / 1ps

module lph_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lph_pkg::dp_status_t status_in,
  output lph_pkg::ctrl_cmd_t  cmd_out,
  output logic               busy
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and datapath commands
  always_comb begin
    cmd_out    = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd_out.clear_wr = 1'b1;
        if (status_in.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_out.load = 1'b1;
          state_next   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status_in.slot_hit || status_in.slot_empty || status_in.probe_last) begin
          cmd_out.finish = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd_out.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> rtl/lph_datapath.sv
// slot memory, probe pointer, live count and result registers
`timescale 1ns / 1ps

module lph_datapath #(
  parameter int TABLE_SLOTS = 512,
  parameter int KEY_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lph_pkg::ctrl_cmd_t            cmd_in,
  output lph_pkg::dp_status_t           status_out,
  input  logic                          cmd,
  input  logic [lph_pkg::IN_KEY_W-1:0]  key,
  input  logic [lph_pkg::DATA_W-1:0]    value,
  output logic                          done,
  output logic                          found,
  output logic [lph_pkg::DATA_W-1:0]    read_value,
  output logic                          status,
  output logic [lph_pkg::FILL_W-1:0]    fill_count
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int SLOT_W = lph_pkg::SLOT_W;
  localparam int WORD_W = SLOT_W + KEY_BITS + lph_pkg::DATA_W;

  // slot memory: state, key and value per slot
  logic [WORD_W-1:0] mem [TABLE_SLOTS];
  logic [WORD_W-1:0] rdata;
  logic [IDX_W-1:0]  raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  // operation registers
  logic                       op_cmd;
  logic [KEY_BITS-1:0]        op_key;
  logic [lph_pkg::DATA_W-1:0] op_value;
  logic [IDX_W-1:0]           pos;
  logic [IDX_W-1:0]           probe_n;
  logic                       have_free;
  logic [IDX_W-1:0]           free_pos;
  logic [CNT_W-1:0]           live_count;
  logic [CNT_W-1:0]           live_count_next;
  logic [IDX_W-1:0]           clr_addr;

  logic [IDX_W-1:0]           home;
  logic [SLOT_W-1:0]          rd_state;
  logic [KEY_BITS-1:0]        rd_key;
  logic [lph_pkg::DATA_W-1:0] rd_val;
  logic                       slot_live;
  logic                       slot_hit;
  logic                       free_any;
  logic [IDX_W-1:0]           free_at;
  logic [lph_pkg::DATA_W-1:0] res_value;
  logic                       res_status;

  assign home      = IDX_W'(key[KEY_BITS-1:0]);
  assign rd_state  = rdata[WORD_W-1 -: SLOT_W];
  assign rd_key    = rdata[lph_pkg::DATA_W +: KEY_BITS];
  assign rd_val    = rdata[lph_pkg::DATA_W-1:0];
  assign slot_live = (rd_state == lph_pkg::SLOT_LIVE);
  assign slot_hit  = slot_live && (rd_key == op_key);
  assign free_any  = have_free || !slot_live;
  assign free_at   = have_free ? free_pos : pos;

  assign status_out.slot_hit   = slot_hit;
  assign status_out.slot_empty = (rd_state == lph_pkg::SLOT_EMPTY);
  assign status_out.probe_last = (probe_n == IDX_W'(TABLE_SLOTS - 1));
  assign status_out.clear_last = (clr_addr == IDX_W'(TABLE_SLOTS - 1));

  // read address: home slot on load, next slot on a probe step
  always_comb begin
    if (cmd_in.load) begin
      raddr = home;
    end else if (cmd_in.step) begin
      raddr = pos + IDX_W'(1);
    end else begin
      raddr = pos;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  // clearing writes, and slot update and result decision at the end of the probe
  always_comb begin
    mem_we          = 1'b0;
    waddr           = pos;
    wdata           = {lph_pkg::SLOT_LIVE, op_key, op_value};
    live_count_next = live_count;
    res_value       = '0;
    res_status      = lph_pkg::STATUS_OK;
    if (cmd_in.clear_wr) begin
      mem_we = 1'b1;
      waddr  = clr_addr;
      wdata  = {lph_pkg::SLOT_EMPTY, {KEY_BITS{1'b0}}, {lph_pkg::DATA_W{1'b0}}};
    end else if (cmd_in.finish) begin
      case (op_cmd)
        lph_pkg::CMD_LOOKUP: begin
          if (slot_hit) begin
            res_value = rd_val;
          end
        end
        lph_pkg::CMD_SET: begin
          if (op_value == '0) begin
            // delete leaves a tombstone
            if (slot_hit) begin
              mem_we          = 1'b1;
              wdata           = {lph_pkg::SLOT_TOMB, op_key, rd_val};
              live_count_next = live_count - CNT_W'(1);
            end
          end else if (slot_hit) begin
            mem_we = 1'b1;
          end else if (free_any) begin
            mem_we          = 1'b1;
            waddr           = free_at;
            live_count_next = live_count + CNT_W'(1);
          end else begin
            res_status = lph_pkg::STATUS_NO_ROOM;
          end
        end
        default: begin
          res_status = lph_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // probe registers
  always_ff @(posedge clk) begin
    if (cmd_in.load) begin
      op_cmd    <= cmd;
      op_key    <= key[KEY_BITS-1:0];
      op_value  <= value;
      pos       <= home;
      probe_n   <= '0;
      have_free <= 1'b0;
    end else if (cmd_in.step) begin
      pos     <= pos + IDX_W'(1);
      probe_n <= probe_n + IDX_W'(1);
      if (!have_free && !slot_live) begin
        have_free <= 1'b1;
        free_pos  <= pos;
      end
    end
  end

  // clearing sweep address and live count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      live_count <= '0;
    end else begin
      if (cmd_in.clear_wr) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      live_count <= live_count_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_in.finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd_in.finish) begin
      found      <= slot_hit;
      read_value <= res_value;
      status     <= res_status;
      fill_count <= lph_pkg::FILL_W'(live_count_next);
    end
  end

endmodule

>>> rtl/linear_probe_hash_table.sv
// top level of the linear probe hash table
`timescale 1ns / 1ps

// Fixed-capacity hash table with linear probing and tombstones. After reset the
// block sweeps the slot memory to empty, one slot per cycle, and busy stays high
// during the sweep, before the first transaction. A transaction is taken when
// start is high and busy is low; the block then reads one slot per cycle from
// its slot memory, which has one read and one write port, starting at the home
// slot (low key bits), until it hits the key, meets an empty slot or has visited
// every slot. The result appears for exactly one cycle with done high, in the
// cycle after the last probe, and must be captured then; busy is already low in
// that cycle, so a new transaction may start at its end.
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS = 512,
  parameter int KEY_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [lph_pkg::IN_KEY_W-1:0]  key,
  input  logic [lph_pkg::DATA_W-1:0]    value,
  output logic                          done,
  output logic                          found,
  output logic [lph_pkg::DATA_W-1:0]    read_value,
  output logic                          status,
  output logic [lph_pkg::FILL_W-1:0]    fill_count
);

  lph_pkg::ctrl_cmd_t  ctrl_cmd;
  lph_pkg::dp_status_t dp_status;

  // controller
  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .status_in (dp_status),
    .cmd_out   (ctrl_cmd),
    .busy      (busy)
  );

  // datapath
  lph_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (ctrl_cmd),
    .status_out (dp_status),
    .cmd        (cmd),
    .key        (key),
    .value      (value),
    .done       (done),
    .found      (found),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count)
  );

  // result strobe comes only while the block is free for the next transaction
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not start probing");

  // a failed set only happens when the key was absent
  assert property (@(posedge clk) disable iff (rst) (done && status) |-> !found)
    else $error("set failure reported for a present key");

  // a miss never returns data
  assert property (@(posedge clk) disable iff (rst) (done && !found) |-> (read_value == '0))
    else $error("nonzero read value on a miss");

endmodule
